/* sv/recs80_pkg.sv */
// Shared types and constants for the space-modulated infrared frame encoder.
`timescale 1ns / 1ps

package recs80_pkg;

  localparam int OP_W     = 2;
  localparam int CMD_W    = 11;
  localparam int PERIOD_W = 10;
  localparam int MARK_W   = 8;
  localparam int TRAIL_W  = 4;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [MARK_W-1:0]   MARK_RST   = 8'd7;
  localparam logic [PERIOD_W-1:0] SPACE0_RST = 10'd189;
  localparam logic [PERIOD_W-1:0] SPACE1_RST = 10'd287;
  localparam logic [TRAIL_W-1:0]  TRAIL_RST  = 4'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd7;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SEND   = 2'd1,
    OP_REPEAT = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MARK  = 3'd1,
    PH_SPACE = 3'd2,
    PH_STOP  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_MARK   = 2'd0,
    REG_SPACE0 = 2'd1,
    REG_SPACE1 = 2'd2,
    REG_TRAIL  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MARK_W-1:0]   mark_length;
    logic [PERIOD_W-1:0] space_zero_length;
    logic [PERIOD_W-1:0] space_one_length;
    logic [TRAIL_W-1:0]  trailer_count;
  } cfg_t;

  typedef struct packed {
    logic                carrier_on;
    logic [PERIOD_W-1:0] next_period;
    logic                frame_started;
    logic                stop_done;
    logic                busy_res;
  } res_t;

endpackage

/* sv/recs80_cfg.sv */
// APB-style configuration register bank for the infrared frame encoder.
`timescale 1ns / 1ps

module recs80_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [recs80_pkg::ADDR_W-1:0] paddr,
  input  logic [recs80_pkg::DATA_W-1:0] pwdata,
  output logic [recs80_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output recs80_pkg::cfg_t             cfg
);
  import recs80_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_length       <= MARK_RST;
      cfg_r.space_zero_length <= SPACE0_RST;
      cfg_r.space_one_length  <= SPACE1_RST;
      cfg_r.trailer_count     <= TRAIL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MARK:   cfg_r.mark_length       <= pwdata[MARK_W-1:0];
        REG_SPACE0: cfg_r.space_zero_length <= pwdata[PERIOD_W-1:0];
        REG_SPACE1: cfg_r.space_one_length  <= pwdata[PERIOD_W-1:0];
        REG_TRAIL:  cfg_r.trailer_count     <= pwdata[TRAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MARK:   prdata = DATA_W'(cfg_r.mark_length);
      REG_SPACE0: prdata = DATA_W'(cfg_r.space_zero_length);
      REG_SPACE1: prdata = DATA_W'(cfg_r.space_one_length);
      REG_TRAIL:  prdata = DATA_W'(cfg_r.trailer_count);
      default:    prdata = '0;
    endcase
  end

endmodule

/* sv/recs80_step.sv */
// Frame sequencer state and the per-item next-state and result logic.
`timescale 1ns / 1ps

module recs80_step #(
  parameter int NUM_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  recs80_pkg::op_t              op,
  input  logic [recs80_pkg::CMD_W-1:0] cmd,
  input  recs80_pkg::cfg_t             cfg,
  output recs80_pkg::res_t             res
);
  import recs80_pkg::*;

  localparam int BC_W = $clog2(NUM_BITS + 1);
  localparam logic [NUM_BITS-1:0] TOG_MASK = NUM_BITS'(1) << (NUM_BITS - 2);

  phase_t              phase_r, phase_nxt;
  logic [NUM_BITS-1:0] shift_r, shift_nxt;
  logic [BC_W-1:0]     bc_r, bc_nxt, bc_inc;
  logic [TRAIL_W-1:0]  td_r, td_nxt, td_inc;
  logic [NUM_BITS-1:0] latch_r, latch_nxt, start_word;
  logic                toggle_r, toggle_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [CMD_W+NUM_BITS-1:0] cmd_ext;
  logic [NUM_BITS-1:0] cmd_w;
  logic                carrier, started, stopped;

  assign cmd_ext = {{NUM_BITS{1'b0}}, cmd};
  assign cmd_w   = cmd_ext[NUM_BITS-1:0];
  assign bc_inc  = bc_r + 1'b1;
  assign td_inc  = td_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shift_r  <= '0;
      bc_r     <= '0;
      td_r     <= '0;
      latch_r  <= '0;
      toggle_r <= 1'b1;
      period_r <= PERIOD_RST;
    end else begin
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      bc_r     <= bc_nxt;
      td_r     <= td_nxt;
      latch_r  <= latch_nxt;
      toggle_r <= toggle_nxt;
      period_r <= period_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    bc_nxt     = bc_r;
    td_nxt     = td_r;
    latch_nxt  = latch_r;
    toggle_nxt = toggle_r;
    period_nxt = period_r;
    carrier    = 1'b0;
    started    = 1'b0;
    stopped    = 1'b0;
    start_word = latch_r;
    if (fire) begin
      unique case (op)
        OP_TICK: begin
          unique case (phase_r)
            PH_MARK, PH_STOP: begin
              period_nxt = PERIOD_W'(cfg.mark_length);
              carrier    = 1'b1;
              phase_nxt  = (phase_r == PH_MARK) ? PH_SPACE : PH_TRAIL;
            end
            PH_SPACE: begin
              period_nxt = shift_r[NUM_BITS-1] ? cfg.space_one_length
                                               : cfg.space_zero_length;
              shift_nxt  = shift_r << 1;
              bc_nxt     = bc_inc;
              phase_nxt  = (bc_inc >= BC_W'(NUM_BITS)) ? PH_STOP : PH_MARK;
            end
            PH_TRAIL: begin
              period_nxt = cfg.space_zero_length;
              td_nxt     = td_inc;
              if (td_inc >= cfg.trailer_count) begin
                bc_nxt    = '0;
                td_nxt    = '0;
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        OP_SEND, OP_REPEAT: begin
          if (op == OP_SEND) begin
            start_word = cmd_w | (toggle_r ? TOG_MASK : '0);
            latch_nxt  = start_word;
          end
          if (start_word != '0 && phase_r == PH_IDLE) begin
            shift_nxt = start_word;
            phase_nxt = PH_MARK;
            started   = 1'b1;
          end
        end
        OP_STOP: begin
          if (latch_r == '0 || phase_r == PH_IDLE) begin
            toggle_nxt = ~toggle_r;
            stopped    = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.carrier_on    = carrier;
    res.next_period   = period_nxt;
    res.frame_started = started;
    res.stop_done     = stopped;
    res.busy_res      = (phase_nxt != PH_IDLE);
  end

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bc_r == '0 && td_r == '0))
    else $error("bit or trailer count not cleared while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= BC_W'(NUM_BITS))
    else $error("bit count ran past the frame length");

  a_trailer_only: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_TRAIL) |-> (td_r == '0))
    else $error("trailer count nonzero outside the trailer");

endmodule

/* sv/recs80_ir_pulse_encoder.sv */
// Top level of the space-modulated infrared frame encoder.
// Usage: each input item carries an opcode (tick, send, repeat, stop) and a
// command word that only send uses. Every item yields exactly one result item
// with the carrier state and length of the next timer period, whether a frame
// started, whether a stop was taken, and whether a frame is in progress.
// A result with stop_done low for a stop item means the stop must be retried.
// The item is taken into an input register; the sequencer computes the result
// from it and loads it into the result register, which raises out_valid. The
// result is held until a clock edge on which out_stall is low takes it.
// When the receiver stalls, the result register holds its item, the input
// register takes one more item, and then in_stall rises until the result
// is taken. Configuration registers sit on the APB-style port at byte
// addresses 0, 4, 8 and 12 and should be written only while no item is in
// flight. Synchronous reset clears the pipeline, stops any frame, sets the
// toggle to one and loads the default lengths.
`timescale 1ns / 1ps

module recs80_ir_pulse_encoder #(
  parameter int NUM_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [recs80_pkg::OP_W-1:0]     in_opcode,
  input  logic [recs80_pkg::CMD_W-1:0]    in_command_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_carrier_on,
  output logic [recs80_pkg::PERIOD_W-1:0] out_next_period,
  output logic                            out_frame_started,
  output logic                            out_stop_done,
  output logic                            out_busy_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [recs80_pkg::ADDR_W-1:0]   paddr,
  input  logic [recs80_pkg::DATA_W-1:0]   pwdata,
  output logic [recs80_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);
  import recs80_pkg::*;

  logic             in_vld_r;
  logic [OP_W-1:0]  in_op_r;
  logic [CMD_W-1:0] in_cmd_r;
  logic             out_vld_r;
  res_t             res_r;
  res_t             res;
  cfg_t             cfg;
  logic             adv;
  logic             fire;
  logic             take;

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;
  assign take     = in_valid && !in_stall;

  recs80_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  recs80_step #(
    .NUM_BITS (NUM_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .op    (op_t'(in_op_r)),
    .cmd   (in_cmd_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op_r  <= in_opcode;
      in_cmd_r <= in_command_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_carrier_on    = res_r.carrier_on;
  assign out_next_period   = res_r.next_period;
  assign out_frame_started = res_r.frame_started;
  assign out_stop_done     = res_r.stop_done;
  assign out_busy_res      = res_r.busy_res;

  a_carrier_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.carrier_on) |-> res_r.busy_res)
    else $error("carrier reported on outside a frame");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.frame_started) |-> (res_r.busy_res && !res_r.stop_done))
    else $error("frame start reported without busy or together with stop");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (in_vld_r && $stable(in_op_r) && $stable(in_cmd_r)))
    else $error("buffered item lost while the result side stalled");

endmodule
